[rtl/elastic_angle_inverse_cdf_sampler_defines.svh]
// Assertion macros used by the sampler control FSM.
`ifndef ELASTIC_ANGLE_INVERSE_CDF_SAMPLER_DEFINES_SVH
`define ELASTIC_ANGLE_INVERSE_CDF_SAMPLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define EAICS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("eaics: same-cycle check failed");
`define EAICS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("eaics: next-cycle check failed");
`else
`define EAICS_ASSERT_IMP(lbl, ante, cons)
`define EAICS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/eaics_pkg.sv]
`default_nettype none
package eaics_pkg;

    localparam int MATERIALS_DEF     = 4;
    localparam int GRID_POINTS_DEF   = 256;
    localparam int TABLE_ENTRIES_DEF = 128;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] A_GRID_SCALE = 3'd0;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_WRITE, S_GRID, S_BASE, S_BUCKET, S_RD_BR, S_BR,
        S_SRCH, S_SCMP, S_NODE0, S_NODE1, S_NORM, S_M1, S_M2, S_M3, S_M4,
        S_M5, S_M6, S_M7, S_ABS, S_DIV0, S_DIV, S_TMUL, S_SHIFT, S_ADD,
        S_FINISH
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_WRITE, DP_GRID, DP_BASE, DP_BUCKET, DP_BRACKET,
        DP_SCMP, DP_NODE0, DP_NODE1, DP_NORM, DP_M1, DP_M2, DP_M3, DP_M4,
        DP_M5, DP_M6, DP_M7, DP_ABS, DP_DIV0, DP_DIV, DP_TMUL, DP_SHIFT,
        DP_ADD, DP_OUT
    } t_dp_op;

    typedef enum logic [2:0] {
        RD_BUCKET, RD_K, RD_I, RD_I1
    } t_rd_sel;

    typedef struct packed {
        t_dp_op  op;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic mat_ok;
        logic search_more;
        logic resid_pos;
        logic norm_done;
        logic den_zero;
        logic div_sat;
        logic div_last;
    } t_status;

endpackage
`default_nettype wire

[rtl/eaics_ifs.sv]
`default_nettype none
interface eaics_req_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [1:0]         material;
    logic [7:0]         grid_point;
    logic [6:0]         entry;
    logic [31:0]        prob_or_cutoff;
    logic [31:0]        mu_or_offset;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic [6:0]         lower_hint;
    logic [6:0]         upper_hint;
    logic [31:0]        rand_grid;
    logic [31:0]        rand_angle;

    modport source (output valid, operation, material, grid_point, entry, prob_or_cutoff,
                    mu_or_offset, coef_a, coef_b, lower_hint, upper_hint, rand_grid,
                    rand_angle, input ready);
    modport sink (input valid, operation, material, grid_point, entry, prob_or_cutoff,
                  mu_or_offset, coef_a, coef_b, lower_hint, upper_hint, rand_grid,
                  rand_angle, output ready);
endinterface

interface eaics_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] mu_out;
    logic        used_upper_grid;
    logic [6:0]  interval;

    modport source (output valid, mu_out, used_upper_grid, interval, input ready);
    modport sink (input valid, mu_out, used_upper_grid, interval, output ready);
endinterface
`default_nettype wire

[rtl/elastic_angle_inverse_cdf_sampler.sv]
// Elastic deflection sampler with tabulated inverse distributions.
// Requests arrive on i_req (valid/ready). operation 0 loads one table entry
// and its bucket bracket; operation 1 draws a sample for a material and grid
// point. Every request yields exactly one response on o_rsp (zeros for loads).
// grid_scale is set through the APB port at byte address 0; pready is tied high.
// One request is in flight at a time; i_req.ready is high while the engine is
// idle, even if the previous response still waits in the output register.
// Sequence: a load decodes the request and writes one table entry. A sample
// runs search probes (one table memory read each, at most 7 probes for 128
// entries), then node fetches, a normalize loop, 7 multiply steps and a
// 30-step restoring divider; a sample at or below its node skips the
// interpolation.
// If o_rsp stalls, the finished result is held until the output register frees.
// Synchronous active-low reset clears the control state and grid_scale; table
// contents are not cleared and must be loaded before sampling.
`default_nettype none
module elastic_angle_inverse_cdf_sampler #(
    parameter int MATERIALS     = eaics_pkg::MATERIALS_DEF,
    parameter int GRID_POINTS   = eaics_pkg::GRID_POINTS_DEF,
    parameter int TABLE_ENTRIES = eaics_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    eaics_req_if.sink                     i_req,
    eaics_rsp_if.source                   o_rsp,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [eaics_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import eaics_pkg::*;

    logic [31:0] r_grid_scale;
    t_cmd        w_cmd;
    t_status     w_st;

    assign pready = 1'b1;
    assign prdata = (paddr == A_GRID_SCALE) ? r_grid_scale : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_scale <= '0;
        end else if (psel && penable && pwrite && paddr == A_GRID_SCALE) begin
            r_grid_scale <= pwdata;
        end
    end

    eaics_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    eaics_datapath #(
        .MATERIALS     (MATERIALS),
        .GRID_POINTS   (GRID_POINTS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_st              (w_st),
        .i_grid_scale      (r_grid_scale),
        .i_operation       (i_req.operation),
        .i_material        (i_req.material),
        .i_grid_point      (i_req.grid_point),
        .i_entry           (i_req.entry),
        .i_prob_or_cutoff  (i_req.prob_or_cutoff),
        .i_mu_or_offset    (i_req.mu_or_offset),
        .i_coef_a          (i_req.coef_a),
        .i_coef_b          (i_req.coef_b),
        .i_lower_hint      (i_req.lower_hint),
        .i_upper_hint      (i_req.upper_hint),
        .i_rand_grid       (i_req.rand_grid),
        .i_rand_angle      (i_req.rand_angle),
        .o_mu_out          (o_rsp.mu_out),
        .o_used_upper_grid (o_rsp.used_upper_grid),
        .o_interval        (o_rsp.interval)
    );

endmodule
`default_nettype wire

[rtl/eaics_datapath.sv]
`default_nettype none
module eaics_datapath #(
    parameter int MATERIALS     = 4,
    parameter int GRID_POINTS   = 256,
    parameter int TABLE_ENTRIES = 128
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  eaics_pkg::t_cmd     i_cmd,
    output eaics_pkg::t_status  o_st,
    input  wire  [31:0]         i_grid_scale,
    input  wire                 i_operation,
    input  wire  [1:0]          i_material,
    input  wire  [7:0]          i_grid_point,
    input  wire  [6:0]          i_entry,
    input  wire  [31:0]         i_prob_or_cutoff,
    input  wire  [31:0]         i_mu_or_offset,
    input  wire  signed [31:0]  i_coef_a,
    input  wire  signed [31:0]  i_coef_b,
    input  wire  [6:0]          i_lower_hint,
    input  wire  [6:0]          i_upper_hint,
    input  wire  [31:0]         i_rand_grid,
    input  wire  [31:0]         i_rand_angle,
    output logic [31:0]         o_mu_out,
    output logic                o_used_upper_grid,
    output logic [6:0]          o_interval
);
    import eaics_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int DEPTH  = MATERIALS * GRID_POINTS * TABLE_ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef struct packed {
        logic [31:0]        prob;
        logic [31:0]        mu;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
    } t_entry;

    t_entry mem [DEPTH];
    t_entry r_q;

    logic               r_op;
    logic [1:0]         r_mat;
    logic [7:0]         r_gp;
    logic [6:0]         r_ent;
    logic [31:0]        r_pc, r_mo, r_rg, r_ra;
    logic signed [31:0] r_a, r_b;
    logic [6:0]         r_lo, r_hi;
    logic [63:0]        r_gprod;
    logic [64:0]        r_uprod;
    logic               r_upper;
    logic [ADDR_W-1:0]  r_base;
    logic [31:0]        r_u;
    logic [IDX_W-1:0]   r_bucket, r_i, r_j;
    logic [31:0]        r_p0, r_mu0, r_mu1, r_ad, r_rr, r_mu_res;
    logic               r_dneg;
    logic signed [33:0] r_sab;
    logic signed [31:0] r_dr;
    logic [29:0]        r_dd;
    logic signed [65:0] r_num, r_den, r_acc, r_acc2;
    logic [63:0]        r_nm, r_dm, r_rem;
    logic               r_neg, r_sat, r_pneg;
    logic [30:0]        r_quo;
    logic [4:0]         r_cnt;
    logic [34:0]        r_mag;

    function automatic logic [IDX_W-1:0] f_clamp(input logic [6:0] h);
        if (32'(h) >= TABLE_ENTRIES) return IDX_W'(TABLE_ENTRIES - 1);
        return IDX_W'(h);
    endfunction

    logic [IDX_W:0]       w_ij, w_i1p;
    logic [IDX_W-1:0]     w_k, w_i1, w_idx;
    logic [ADDR_W-1:0]    w_rd_addr, w_wr_addr;
    logic                 w_wr_ok;
    logic [9:0]           w_gpc, w_g;
    logic                 w_up;
    logic [31+IDX_W:0]    w_bprod;
    logic signed [32:0]   w_d33;
    logic [31:0]          w_or;
    logic signed [15:0]   w_d16, w_rs;
    logic [64:0]          w_sh;
    logic signed [31:0]   w_t;
    logic signed [32:0]   w_delta;
    logic signed [65:0]   w_pmag;
    logic signed [36:0]   w_res;
    logic                 w_q0;

    always_comb begin
        w_ij  = (IDX_W+1)'(r_i) + (IDX_W+1)'(r_j);
        w_k   = w_ij[IDX_W:1];
        w_i1p = (IDX_W+1)'(r_i) + (IDX_W+1)'(1);
        w_i1  = (32'(w_i1p) >= TABLE_ENTRIES) ? r_i : w_i1p[IDX_W-1:0];
        case (i_cmd.rd_sel)
            RD_BUCKET: w_idx = r_bucket;
            RD_K:      w_idx = w_k;
            RD_I1:     w_idx = w_i1;
            default:   w_idx = r_i;
        endcase
        w_rd_addr = r_base + ADDR_W'(w_idx);
        w_wr_addr = ADDR_W'((32'(r_mat) * GRID_POINTS + 32'(r_gp)) * TABLE_ENTRIES
                            + 32'(r_ent));
        w_wr_ok = (32'(r_mat) < MATERIALS) && (32'(r_gp) < GRID_POINTS)
                  && (32'(r_ent) < TABLE_ENTRIES);

        w_up  = {12'b0, r_rg, 20'b0} < r_gprod;
        w_gpc = (32'(r_gp) >= GRID_POINTS) ? 10'(GRID_POINTS - 1) : 10'(r_gp);
        if (w_up && (32'(w_gpc) + 1 < GRID_POINTS)) w_g = w_gpc + 10'd1;
        else if (w_up) w_g = 10'(GRID_POINTS - 1);
        else w_g = w_gpc;

        w_bprod = (32+IDX_W)'(r_u) * (32+IDX_W)'(TABLE_ENTRIES - 1);

        w_d33 = $signed({1'b0, r_q.prob}) - $signed({1'b0, r_p0});
        w_or  = r_ad | r_rr;
        w_d16 = r_dneg ? -$signed({1'b0, r_ad[14:0]}) : $signed({1'b0, r_ad[14:0]});
        w_rs  = $signed({1'b0, r_rr[14:0]});

        w_q0 = r_nm >= r_dm;
        w_sh = {r_rem, 1'b0};

        if (r_sat) w_t = r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else w_t = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        w_delta = $signed({1'b0, r_mu1}) - $signed({1'b0, r_mu0});
        w_pmag  = r_acc[65] ? -r_acc : r_acc;
        w_res   = r_pneg ? $signed({5'b0, r_mu0}) - $signed({2'b0, r_mag})
                         : $signed({5'b0, r_mu0}) + $signed({2'b0, r_mag});
    end

    always_comb begin
        o_st.is_write    = r_op == OP_WRITE;
        o_st.mat_ok      = 32'(r_mat) < MATERIALS;
        o_st.search_more = (IDX_W+1)'(r_j) >= (IDX_W+1)'(r_i) + (IDX_W+1)'(2);
        o_st.resid_pos   = r_u > r_p0;
        o_st.norm_done   = w_or[31:15] == 17'd0;
        o_st.den_zero    = r_den == 66'sd0;
        o_st.div_sat     = r_sat;
        o_st.div_last    = r_cnt == 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_WRITE && w_wr_ok) begin
            mem[w_wr_addr] <= '{prob: r_pc, mu: r_mo, a: r_a, b: r_b,
                                lo: f_clamp(r_lo), hi: f_clamp(r_hi)};
        end
        r_q <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_mu_out          <= '0;
            o_used_upper_grid <= 1'b0;
            o_interval        <= '0;
        end else if (i_cmd.op == DP_OUT) begin
            o_mu_out          <= r_mu_res;
            o_used_upper_grid <= r_upper;
            o_interval        <= 7'(r_i);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_op <= i_operation;  r_mat <= i_material;  r_gp <= i_grid_point;
                r_ent <= i_entry;  r_pc <= i_prob_or_cutoff;  r_mo <= i_mu_or_offset;
                r_a <= i_coef_a;  r_b <= i_coef_b;  r_lo <= i_lower_hint;
                r_hi <= i_upper_hint;  r_rg <= i_rand_grid;  r_ra <= i_rand_angle;
                r_i <= '0;  r_upper <= 1'b0;  r_mu_res <= '0;
            end
            DP_GRID: begin
                r_gprod <= 64'(r_mo) * 64'(i_grid_scale);
                r_uprod <= 65'(r_ra) * (65'h1_0000_0000 - 65'(r_pc));
            end
            DP_BASE: begin
                r_upper <= w_up;
                r_base  <= ADDR_W'((32'(r_mat) * GRID_POINTS + 32'(w_g)) * TABLE_ENTRIES);
                r_u     <= 32'(33'(r_pc) + r_uprod[64:32]);
            end
            DP_BUCKET:  r_bucket <= w_bprod[31+IDX_W:32];
            DP_BRACKET: begin
                r_i <= r_q.lo;
                r_j <= r_q.hi;
            end
            DP_SCMP: begin
                if (r_u > r_q.prob) r_i <= w_k;
                else r_j <= w_k;
            end
            DP_NODE0: begin
                r_p0 <= r_q.prob;  r_mu0 <= r_q.mu;  r_mu_res <= r_q.mu;
                r_a <= r_q.a;  r_b <= r_q.b;
            end
            DP_NODE1: begin
                r_mu1  <= r_q.mu;
                r_dneg <= w_d33[32];
                r_ad   <= w_d33[32] ? 32'(-w_d33) : 32'(w_d33);
                r_rr   <= r_u - r_p0;
            end
            DP_NORM: begin
                // coarse step first, the truncation composes
                if (w_or[31:23] != 9'd0) begin
                    r_ad <= r_ad >> 8;
                    r_rr <= r_rr >> 8;
                end else begin
                    r_ad <= r_ad >> 1;
                    r_rr <= r_rr >> 1;
                end
            end
            DP_M1: begin
                r_sab <= 34'sd16777216 + 34'(r_a) + 34'(r_b);
                r_dr  <= w_d16 * w_rs;
                r_dd  <= 30'(r_ad[14:0]) * 30'(r_ad[14:0]);
            end
            DP_M2: r_num  <= r_sab * r_dr;
            DP_M3: r_acc  <= r_a * w_d16;
            DP_M4: r_acc2 <= r_b * w_rs;
            DP_M5: r_acc  <= r_acc + r_acc2;
            DP_M6: r_acc  <= $signed(r_acc[48:0]) * w_rs;
            DP_M7: r_den  <= r_acc + $signed({12'b0, r_dd, 24'b0});
            DP_ABS: begin
                r_nm  <= r_num[65] ? 64'(-r_num) : 64'(r_num);
                r_dm  <= r_den[65] ? 64'(-r_den) : 64'(r_den);
                r_neg <= r_num[65] ^ r_den[65];
            end
            DP_DIV0: begin
                r_sat <= {1'b0, r_nm} >= {r_dm, 1'b0};
                r_rem <= w_q0 ? r_nm - r_dm : r_nm;
                r_quo <= 31'(w_q0);
                r_cnt <= 5'd30;
            end
            DP_DIV: begin
                if (w_sh >= {1'b0, r_dm}) begin
                    r_rem <= 64'(w_sh - {1'b0, r_dm});
                    r_quo <= {r_quo[29:0], 1'b1};
                end else begin
                    r_rem <= w_sh[63:0];
                    r_quo <= {r_quo[29:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
            end
            DP_TMUL: r_acc <= w_t * w_delta;
            DP_SHIFT: begin
                r_pneg <= r_acc[65];
                r_mag  <= w_pmag[64:30];
            end
            DP_ADD: begin
                if (w_res < 0) r_mu_res <= '0;
                else if (w_res > 37'sh0_FFFF_FFFF) r_mu_res <= 32'hFFFF_FFFF;
                else r_mu_res <= w_res[31:0];
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[rtl/eaics_ctrl.sv]
`default_nettype none
`include "elastic_angle_inverse_cdf_sampler_defines.svh"
module eaics_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    input  eaics_pkg::t_status i_st,
    output eaics_pkg::t_cmd    o_cmd
);
    import eaics_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == DP_OUT) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = DP_NOP;
        o_cmd.rd_sel = RD_I;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_st.is_write) n_state = S_WRITE;
                else if (!i_st.mat_ok) n_state = S_FINISH;
                else n_state = S_GRID;
            end
            S_WRITE: begin
                o_cmd.op = DP_WRITE;
                n_state  = S_FINISH;
            end
            S_GRID:   begin o_cmd.op = DP_GRID;   n_state = S_BASE;   end
            S_BASE:   begin o_cmd.op = DP_BASE;   n_state = S_BUCKET; end
            S_BUCKET: begin o_cmd.op = DP_BUCKET; n_state = S_RD_BR;  end
            S_RD_BR: begin
                o_cmd.rd_sel = RD_BUCKET;
                n_state      = S_BR;
            end
            S_BR: begin o_cmd.op = DP_BRACKET; n_state = S_SRCH; end
            S_SRCH: begin
                // probe the midpoint, or fetch node i once the bracket is tight
                if (i_st.search_more) begin
                    o_cmd.rd_sel = RD_K;
                    n_state      = S_SCMP;
                end else begin
                    o_cmd.rd_sel = RD_I;
                    n_state      = S_NODE0;
                end
            end
            S_SCMP: begin o_cmd.op = DP_SCMP; n_state = S_SRCH; end
            S_NODE0: begin
                o_cmd.op     = DP_NODE0;
                o_cmd.rd_sel = RD_I1;
                n_state      = S_NODE1;
            end
            S_NODE1: begin
                o_cmd.op = DP_NODE1;
                n_state  = i_st.resid_pos ? S_NORM : S_FINISH;
            end
            S_NORM: begin
                if (i_st.norm_done) n_state = S_M1;
                else o_cmd.op = DP_NORM;
            end
            S_M1: begin o_cmd.op = DP_M1; n_state = S_M2; end
            S_M2: begin o_cmd.op = DP_M2; n_state = S_M3; end
            S_M3: begin o_cmd.op = DP_M3; n_state = S_M4; end
            S_M4: begin o_cmd.op = DP_M4; n_state = S_M5; end
            S_M5: begin o_cmd.op = DP_M5; n_state = S_M6; end
            S_M6: begin o_cmd.op = DP_M6; n_state = S_M7; end
            S_M7: begin o_cmd.op = DP_M7; n_state = S_ABS; end
            S_ABS: begin
                if (i_st.den_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.op = DP_ABS;
                    n_state  = S_DIV0;
                end
            end
            S_DIV0: begin o_cmd.op = DP_DIV0; n_state = S_DIV; end
            S_DIV: begin
                if (i_st.div_sat) begin
                    n_state = S_TMUL;
                end else begin
                    o_cmd.op = DP_DIV;
                    if (i_st.div_last) n_state = S_TMUL;
                end
            end
            S_TMUL:  begin o_cmd.op = DP_TMUL;  n_state = S_SHIFT; end
            S_SHIFT: begin o_cmd.op = DP_SHIFT; n_state = S_ADD;   end
            S_ADD:   begin o_cmd.op = DP_ADD;   n_state = S_FINISH; end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `EAICS_ASSERT_NXT(a_accept_decode, r_state == S_IDLE && i_in_valid, r_state == S_DECODE)
    `EAICS_ASSERT_IMP(a_probe_order, r_state == S_SCMP, $past(r_state) == S_SRCH)
    `EAICS_ASSERT_NXT(a_result_waits, r_state == S_FINISH && r_out_valid && !i_out_ready, r_state == S_FINISH && r_out_valid)

endmodule
`default_nettype wire
